// File: hdl/nnr_pkg.sv
// Shared constants, codes, types and helper functions for the nearest-neighbor resizer.
// Used by the channel interfaces, the ratio divider and the top level.
package nnr_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int DIMX_W = COL_W + 1;
    localparam int DIMY_W = ROW_W + 1;
    localparam int DIV_W  = (DIMX_W > DIMY_W) ? DIMX_W : DIMY_W;
    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);

    localparam int CHAN_W    = 8;
    localparam int PIX_W     = 3 * CHAN_W;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = CFG_IDX_W'(3);

    typedef struct packed {
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } div_result_t;

    // A zero dimension counts as one; anything above the maximum counts as the maximum.
    function automatic logic [DIMX_W-1:0] clamp_width(input logic [CFG_DATA_W-1:0] v);
        logic [DIMX_W-1:0] r;
        if (v == '0)
        begin
            r = DIMX_W'(1);
        end
        else if (int'(v) > MAX_WIDTH)
        begin
            r = DIMX_W'(MAX_WIDTH);
        end
        else
        begin
            r = DIMX_W'(v);
        end
        return r;
    endfunction

    function automatic logic [DIMY_W-1:0] clamp_height(input logic [CFG_DATA_W-1:0] v);
        logic [DIMY_W-1:0] r;
        if (v == '0)
        begin
            r = DIMY_W'(1);
        end
        else if (int'(v) > MAX_HEIGHT)
        begin
            r = DIMY_W'(MAX_HEIGHT);
        end
        else
        begin
            r = DIMY_W'(v);
        end
        return r;
    endfunction

endpackage

// File: hdl/nnr_ifs.sv
// Valid/ready channel interfaces for source pixels, scaled pixels and register writes.
// Depends on nnr_pkg for field widths.
interface nnr_pix_in_if
    import nnr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              op;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;

    modport source (output valid, op, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, op, red_in, green_in, blue_in, output ready);
endinterface

interface nnr_pix_out_if
    import nnr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              frame_end;

    modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

interface nnr_cfg_if
    import nnr_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/nnr_div.sv
// Restoring divider producing quotient and remainder, one quotient bit per cycle.
// Depends on nnr_pkg for the operand width and the result struct.
module nnr_div
    import nnr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output div_result_t      result
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dsr_reg;
    logic [DIV_W:0]   trial;
    logic             take;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        take  = (trial >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= take ? DIV_W'(trial - {1'b0, dsr_reg}) : DIV_W'(trial);
            quo_reg <= {quo_reg[DIV_W-2:0], take};
        end
    end

    assign busy       = (cnt_reg != '0);
    assign result.quo = quo_reg;
    assign result.rem = rem_reg;

endmodule

// File: hdl/nearest_neighbor_resize.sv
// Top level of the nearest-neighbor RGB image resizer with its frame store.
// Depends on nnr_pkg, the channel interfaces and nnr_div.
//
// Load beats write source pixels in row-major order into a single-port frame store;
// read beats return destination pixels in row-major order, each one read from the
// store into the output register. The frame store port serves one load or one read
// per cycle, and a pixel beat of either kind is accepted only while the output
// register is empty or is being emptied in the same cycle, so a stalled scaled beat
// holds up loads as well. Source coordinates are stepped incrementally from the
// integer quotient and remainder of source over destination size, which two dividers
// work out one bit per cycle after reset and after every write to a size register;
// meanwhile no pixel beat is accepted, while register writes are always taken.
module nearest_neighbor_resize
    import nnr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    nnr_cfg_if.sink       cfg,
    nnr_pix_in_if.sink    pixels,
    nnr_pix_out_if.source scaled
);

    localparam int SX_SUM_W = DIV_W + 1;
    localparam int RX_SUM_W = DIMX_W + 1;
    localparam int RY_SUM_W = DIMY_W + 1;

    logic [CFG_DATA_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [DIMX_W-1:0]     sw, dw;
    logic [DIMY_W-1:0]     sh, dh;

    logic [COL_W-1:0]  load_col_reg, load_col_next;
    logic [ROW_W-1:0]  load_row_reg, load_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [COL_W-1:0]  sx_reg, sx_next;
    logic [DIMX_W-1:0] rx_reg, rx_next;
    logic [ROW_W-1:0]  sy_reg, sy_next;
    logic [DIMY_W-1:0] ry_reg, ry_next;

    logic [SX_SUM_W-1:0] sx_sum, sy_sum;
    logic [RX_SUM_W-1:0] rx_sum;
    logic [RY_SUM_W-1:0] ry_sum;
    logic                col_last, row_last, load_col_last, load_row_last;

    logic        start_reg;
    logic        busy_x, busy_y;
    div_result_t ratio_x, ratio_y;

    logic [PIX_W-1:0]  frame_mem [MAX_WIDTH * MAX_HEIGHT];
    logic [PIX_W-1:0]  rd_data_reg;
    logic              out_valid_reg;
    logic              frame_end_reg;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    logic cfg_fire, in_fire, load_fire, rd_fire, out_fire;

    assign sw = clamp_width(src_w_reg);
    assign dw = clamp_width(dst_w_reg);
    assign sh = clamp_height(src_h_reg);
    assign dh = clamp_height(dst_h_reg);

    nnr_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (DIV_W'(sw)),
        .divisor  (DIV_W'(dw)),
        .busy     (busy_x),
        .result   (ratio_x)
    );

    nnr_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (DIV_W'(sh)),
        .divisor  (DIV_W'(dh)),
        .busy     (busy_y),
        .result   (ratio_y)
    );

    assign cfg.ready    = 1'b1;
    assign pixels.ready = !start_reg && !busy_x && !busy_y && (!out_valid_reg || scaled.ready);

    assign cfg_fire  = cfg.valid && cfg.ready;
    assign in_fire   = pixels.valid && pixels.ready;
    assign load_fire = in_fire && (pixels.op == OP_LOAD);
    assign rd_fire   = in_fire && (pixels.op == OP_READ);
    assign out_fire  = scaled.valid && scaled.ready;

    assign wr_addr = ADDR_W'(load_row_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(load_col_reg);
    assign rd_addr = ADDR_W'(sy_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sx_reg);

    always_comb
    begin
        load_col_last = (DIMX_W'(load_col_reg) + 1'b1 == sw);
        load_row_last = (DIMY_W'(load_row_reg) + 1'b1 == sh);
        col_last      = (DIMX_W'(out_col_reg) + 1'b1 == dw);
        row_last      = (DIMY_W'(out_row_reg) + 1'b1 == dh);

        load_col_next = load_col_reg + 1'b1;
        load_row_next = load_row_reg;
        if (load_col_last)
        begin
            load_col_next = '0;
            load_row_next = load_row_last ? '0 : load_row_reg + 1'b1;
        end

        rx_sum = RX_SUM_W'(rx_reg) + RX_SUM_W'(ratio_x.rem);
        sx_sum = SX_SUM_W'(sx_reg) + SX_SUM_W'(ratio_x.quo);
        if (rx_sum >= RX_SUM_W'(dw))
        begin
            rx_sum = rx_sum - RX_SUM_W'(dw);
            sx_sum = sx_sum + 1'b1;
        end

        ry_sum = RY_SUM_W'(ry_reg) + RY_SUM_W'(ratio_y.rem);
        sy_sum = SX_SUM_W'(sy_reg) + SX_SUM_W'(ratio_y.quo);
        if (ry_sum >= RY_SUM_W'(dh))
        begin
            ry_sum = ry_sum - RY_SUM_W'(dh);
            sy_sum = sy_sum + 1'b1;
        end

        out_col_next = out_col_reg + 1'b1;
        sx_next      = COL_W'(sx_sum);
        rx_next      = DIMX_W'(rx_sum);
        out_row_next = out_row_reg;
        sy_next      = sy_reg;
        ry_next      = ry_reg;
        if (col_last)
        begin
            out_col_next = '0;
            sx_next      = '0;
            rx_next      = '0;
            if (row_last)
            begin
                out_row_next = '0;
                sy_next      = '0;
                ry_next      = '0;
            end
            else
            begin
                out_row_next = out_row_reg + 1'b1;
                sy_next      = ROW_W'(sy_sum);
                ry_next      = DIMY_W'(ry_sum);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg     <= CFG_DATA_W'(MAX_WIDTH);
            src_h_reg     <= CFG_DATA_W'(MAX_HEIGHT);
            dst_w_reg     <= CFG_DATA_W'(MAX_WIDTH);
            dst_h_reg     <= CFG_DATA_W'(MAX_HEIGHT);
            start_reg     <= 1'b1;
            load_col_reg  <= '0;
            load_row_reg  <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            sx_reg        <= '0;
            rx_reg        <= '0;
            sy_reg        <= '0;
            ry_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;

            if (load_fire)
            begin
                load_col_reg <= load_col_next;
                load_row_reg <= load_row_next;
            end

            if (rd_fire)
            begin
                out_col_reg <= out_col_next;
                out_row_reg <= out_row_next;
                sx_reg      <= sx_next;
                rx_reg      <= rx_next;
                sy_reg      <= sy_next;
                ry_reg      <= ry_next;
            end

            if (rd_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_fire)
            begin
                unique case (cfg.index)
                    REG_SRC_WIDTH,
                    REG_SRC_HEIGHT,
                    REG_DST_WIDTH,
                    REG_DST_HEIGHT:
                    begin
                        start_reg    <= 1'b1;
                        load_col_reg <= '0;
                        load_row_reg <= '0;
                        out_col_reg  <= '0;
                        out_row_reg  <= '0;
                        sx_reg       <= '0;
                        rx_reg       <= '0;
                        sy_reg       <= '0;
                        ry_reg       <= '0;
                    end
                    default:
                    begin
                    end
                endcase

                unique case (cfg.index)
                    REG_SRC_WIDTH:  src_w_reg <= cfg.data;
                    REG_SRC_HEIGHT: src_h_reg <= cfg.data;
                    REG_DST_WIDTH:  dst_w_reg <= cfg.data;
                    REG_DST_HEIGHT: dst_h_reg <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            frame_mem[wr_addr] <= {pixels.red_in, pixels.green_in, pixels.blue_in};
        end
        if (rd_fire)
        begin
            rd_data_reg   <= frame_mem[rd_addr];
            frame_end_reg <= col_last && row_last;
        end
    end

    assign scaled.valid     = out_valid_reg;
    assign scaled.red_out   = rd_data_reg[PIX_W-1 -: CHAN_W];
    assign scaled.green_out = rd_data_reg[2*CHAN_W-1 -: CHAN_W];
    assign scaled.blue_out  = rd_data_reg[CHAN_W-1:0];
    assign scaled.frame_end = frame_end_reg;

endmodule
